[hw/rtl/admm_soft_threshold_step_defines.svh]
// Assertion macros for the ADMM soft-threshold block.
`ifndef ADMM_SOFT_THRESHOLD_STEP_DEFINES_SVH
`define ADMM_SOFT_THRESHOLD_STEP_DEFINES_SVH

`ifndef ASSERT_OFF

// cond must hold at every clock edge out of reset
`define ASSERT_HOLDS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("admm_st: invariant violated");

// post must hold in the same cycle as pre
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("admm_st: implication violated");

// post must hold in the cycle after pre
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("admm_st: next-cycle check violated");

`else

`define ASSERT_HOLDS(label, clk, rst, cond)
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

[hw/rtl/admm_st_pkg.sv]
// Shared types, constants and saturation helpers for the ADMM soft-threshold block.
`timescale 1ns / 1ps

package admm_st_pkg;

   // number format
   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 32;

   // fixed field widths
   localparam int DATA_W   = 32;
   localparam int THR_W    = 31;
   localparam int SUM_W    = 64;
   localparam int NUM_SUMS = 5;

   // working width: wide enough for any sum or difference of two values
   localparam int EXT_W  = ((VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W) + 2;
   localparam int PROD_W = 2 * VALUE_WIDTH;
   localparam int WIDE_W = PROD_W + SUM_W;

   // square realignment to 32 fraction bits
   localparam int SQ_RSH = (2 * FRAC_BITS >= 32) ? (2 * FRAC_BITS - 32) : 0;
   localparam int SQ_LSH = (2 * FRAC_BITS < 32) ? (32 - 2 * FRAC_BITS) : 0;

   // sum slots
   localparam int SUM_PRIMAL = 0;
   localparam int SUM_CHANGE = 1;
   localparam int SUM_COEF   = 2;
   localparam int SUM_SPLIT  = 3;
   localparam int SUM_DUAL   = 4;

   // register map
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_EN = CSR_IDX_W'(1);

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic signed [EXT_W-1:0]       ext_type;
   typedef logic [VALUE_WIDTH-1:0]        mag_type;
   typedef logic [SUM_W-1:0]              sum_type;
   typedef logic [NUM_SUMS-1:0][VALUE_WIDTH-1:0] mags_type;
   typedef logic [NUM_SUMS-1:0][SUM_W-1:0]       sums_type;

   // result of the proximal / dual stage
   typedef struct packed {
      value_type split;
      value_type dual;
      mags_type  mags;
   } prox_type;

   // accumulator control for one result transaction
   typedef struct packed {
      logic load;
      logic first;
      logic enable;
   } acc_ctl_type;

   localparam ext_type VAL_MAX = ext_type'({1'b0, {(VALUE_WIDTH-1){1'b1}}});
   localparam ext_type VAL_MIN = -VAL_MAX - ext_type'(1);

   function automatic value_type sat_value(input ext_type v);
      value_type r;
      if (v > VAL_MAX) begin
         r = VAL_MAX[VALUE_WIDTH-1:0];
      end else if (v < VAL_MIN) begin
         r = VAL_MIN[VALUE_WIDTH-1:0];
      end else begin
         r = v[VALUE_WIDTH-1:0];
      end
      return r;
   endfunction

   function automatic ext_type widen(input value_type v);
      return ext_type'(v);
   endfunction

   function automatic mag_type magnitude(input value_type v);
      value_type n;
      n = -v;
      return v[VALUE_WIDTH-1] ? mag_type'(n) : mag_type'(v);
   endfunction

endpackage

[hw/rtl/admm_soft_threshold_step.sv]
// Top level of the ADMM soft-threshold and dual update block.
//
// Usage: one req_ transaction carries one vector element (coefficient,
// previous split, previous dual in req_tdata; first-element flag in
// req_tuser). Each produces exactly one rsp_ transaction with the new split,
// the new dual and the five running sums of squares after that element.
// The element passes the input register, the proximal stage, the squaring
// stage, then the accumulate / result register, which drives rsp_tvalid.
// Throughput: one element per cycle while rsp_tready does not stall the
// pipe; the only loop is the 64-bit saturating add of each running sum.
// Stalls: the four stages form an elastic pipeline; when rsp_tready is low
// the result register holds and req_tready drops once all stages are full.
// Reset clears all stage valids and the sums, sets the threshold to zero and
// enables residual accumulation. The csr_ channel is always ready; write it
// only when no transaction is in flight. Index 0 is the threshold (Q15.16,
// 31 bits), index 1 the residual enable; other indexes are ignored.
// first_element set clears the sums before the element is added, even when
// residual accumulation is off.
`timescale 1ns / 1ps
`include "admm_soft_threshold_step_defines.svh"

module admm_soft_threshold_step (
   input  logic         clock,
   input  logic         reset,

   // input element stream
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // coef_value, prev_split, prev_dual
   input  logic         req_tuser,   // first_element

   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [383:0] rsp_tdata,   // split_value, dual_value, primal_sq_sum,
                                     // change_sq_sum, coef_sq_sum, split_sq_sum,
                                     // dual_sq_sum

   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [admm_st_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]  csr_data
);

   localparam int DW = admm_st_pkg::DATA_W;

   // configuration
   logic [admm_st_pkg::THR_W-1:0] thr_ff;
   logic                          res_en_ff;

   // stage 0: input register
   logic                   s0_valid_ff;
   logic signed [DW-1:0]   s0_coef_ff;
   logic signed [DW-1:0]   s0_split_ff;
   logic signed [DW-1:0]   s0_dual_ff;
   logic                   s0_first_ff;

   // stage 1: proximal results
   logic                   s1_valid_ff;
   admm_st_pkg::prox_type  s1_prox_ff;
   logic                   s1_first_ff;

   // stage 2: squares
   logic                   s2_valid_ff;
   admm_st_pkg::value_type s2_split_ff;
   admm_st_pkg::value_type s2_dual_ff;
   admm_st_pkg::sums_type  s2_sq_ff;
   logic                   s2_first_ff;

   // stage 3: result register (sums live in the accumulator)
   logic                   s3_valid_ff;
   logic [DW-1:0]          s3_split_ff;
   logic [DW-1:0]          s3_dual_ff;

   logic                   req_fire;
   logic                   s1_load;
   logic                   s2_load;
   logic                   s3_load;
   admm_st_pkg::prox_type  prox;
   admm_st_pkg::sums_type  squares;
   admm_st_pkg::sums_type  acc_sums;
   admm_st_pkg::acc_ctl_type acc_ctl;

   // elastic pipeline control: a stage loads when its successor has room
   assign s3_load    = s2_valid_ff && (!s3_valid_ff || rsp_tready);
   assign s2_load    = s1_valid_ff && (!s2_valid_ff || s3_load);
   assign s1_load    = s0_valid_ff && (!s1_valid_ff || s2_load);
   assign req_tready = !s0_valid_ff || s1_load;
   assign req_fire   = req_tvalid && req_tready;

   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= '0;
         res_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            admm_st_pkg::CSR_THRESHOLD:   thr_ff    <= csr_data[admm_st_pkg::THR_W-1:0];
            admm_st_pkg::CSR_RESIDUAL_EN: res_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            s0_valid_ff <= 1'b1;
         end else if (s1_load) begin
            s0_valid_ff <= 1'b0;
         end
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s2_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_load) begin
            s2_valid_ff <= 1'b1;
         end else if (s3_load) begin
            s2_valid_ff <= 1'b0;
         end
         if (s3_load) begin
            s3_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            s3_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s0_coef_ff  <= req_tdata[DW-1:0];
         s0_split_ff <= req_tdata[2*DW-1:DW];
         s0_dual_ff  <= req_tdata[3*DW-1:2*DW];
         s0_first_ff <= req_tuser;
      end
      if (s1_load) begin
         s1_prox_ff  <= prox;
         s1_first_ff <= s0_first_ff;
      end
      if (s2_load) begin
         s2_split_ff <= s1_prox_ff.split;
         s2_dual_ff  <= s1_prox_ff.dual;
         s2_sq_ff    <= squares;
         s2_first_ff <= s1_first_ff;
      end
      if (s3_load) begin
         s3_split_ff <= DW'(admm_st_pkg::widen(s2_split_ff));
         s3_dual_ff  <= DW'(admm_st_pkg::widen(s2_dual_ff));
      end
   end

   admm_st_prox u_prox (
      .coef_value       (s0_coef_ff),
      .prev_split       (s0_split_ff),
      .prev_dual        (s0_dual_ff),
      .shrink_threshold (thr_ff),
      .prox             (prox)
   );

   for (genvar g = 0; g < admm_st_pkg::NUM_SUMS; g++) begin : g_square
      admm_st_square u_square (
         .mag    (s1_prox_ff.mags[g]),
         .square (squares[g])
      );
   end

   assign acc_ctl.load   = s3_load;
   assign acc_ctl.first  = s2_first_ff;
   assign acc_ctl.enable = res_en_ff;

   admm_st_accum u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .squares (s2_sq_ff),
      .sums    (acc_sums)
   );

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {acc_sums[admm_st_pkg::SUM_DUAL],
                        acc_sums[admm_st_pkg::SUM_SPLIT],
                        acc_sums[admm_st_pkg::SUM_COEF],
                        acc_sums[admm_st_pkg::SUM_CHANGE],
                        acc_sums[admm_st_pkg::SUM_PRIMAL],
                        s3_dual_ff,
                        s3_split_ff};

   // an empty input register always takes a transaction
   `ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !s0_valid_ff, req_tready)
   // with accumulation off, a non-first element leaves the sums alone
   `ASSERT_NEXT(a_sums_hold, clock, reset, s3_load && !res_en_ff && !s2_first_ff, $stable(acc_sums))
   // a first element with accumulation off leaves all sums cleared
   `ASSERT_NEXT(a_first_clears, clock, reset, s3_load && !res_en_ff && s2_first_ff, acc_sums == '0)

endmodule

[hw/rtl/admm_st_prox.sv]
// Proximal step: w, soft threshold, new dual, residual differences and magnitudes.
`timescale 1ns / 1ps

module admm_st_prox (
   input  logic signed [admm_st_pkg::DATA_W-1:0] coef_value,
   input  logic signed [admm_st_pkg::DATA_W-1:0] prev_split,
   input  logic signed [admm_st_pkg::DATA_W-1:0] prev_dual,
   input  logic [admm_st_pkg::THR_W-1:0]         shrink_threshold,
   output admm_st_pkg::prox_type                 prox
);

   admm_st_pkg::value_type coef;
   admm_st_pkg::value_type old_split;
   admm_st_pkg::value_type old_dual;
   admm_st_pkg::value_type w;
   admm_st_pkg::value_type split;
   admm_st_pkg::value_type dual;
   admm_st_pkg::value_type primal_diff;
   admm_st_pkg::value_type change_diff;
   admm_st_pkg::ext_type   thr_ext;
   admm_st_pkg::ext_type   w_ext;
   admm_st_pkg::ext_type   split_ext;

   always_comb begin
      coef      = admm_st_pkg::sat_value(admm_st_pkg::ext_type'(coef_value));
      old_split = admm_st_pkg::sat_value(admm_st_pkg::ext_type'(prev_split));
      old_dual  = admm_st_pkg::sat_value(admm_st_pkg::ext_type'(prev_dual));

      w       = admm_st_pkg::sat_value(admm_st_pkg::widen(coef) + admm_st_pkg::widen(old_dual));
      w_ext   = admm_st_pkg::widen(w);
      thr_ext = admm_st_pkg::ext_type'({1'b0, shrink_threshold});

      // shrink toward zero; magnitude never grows so the result fits
      priority if (w_ext > thr_ext) begin
         split_ext = w_ext - thr_ext;
      end else if (w_ext < -thr_ext) begin
         split_ext = w_ext + thr_ext;
      end else begin
         split_ext = '0;
      end
      split = split_ext[admm_st_pkg::VALUE_WIDTH-1:0];

      dual        = admm_st_pkg::sat_value(w_ext - split_ext);
      primal_diff = admm_st_pkg::sat_value(admm_st_pkg::widen(coef) - split_ext);
      change_diff = admm_st_pkg::sat_value(split_ext - admm_st_pkg::widen(old_split));

      prox.split = split;
      prox.dual  = dual;
      prox.mags[admm_st_pkg::SUM_PRIMAL] = admm_st_pkg::magnitude(primal_diff);
      prox.mags[admm_st_pkg::SUM_CHANGE] = admm_st_pkg::magnitude(change_diff);
      prox.mags[admm_st_pkg::SUM_COEF]   = admm_st_pkg::magnitude(coef);
      prox.mags[admm_st_pkg::SUM_SPLIT]  = admm_st_pkg::magnitude(split);
      prox.mags[admm_st_pkg::SUM_DUAL]   = admm_st_pkg::magnitude(dual);
   end

endmodule

[hw/rtl/admm_st_square.sv]
// Squarer: magnitude squared, realigned to Q32.32 and saturated to 64 bits.
`timescale 1ns / 1ps

module admm_st_square (
   input  admm_st_pkg::mag_type mag,
   output admm_st_pkg::sum_type square
);

   logic [admm_st_pkg::PROD_W-1:0] prod;
   logic [admm_st_pkg::WIDE_W-1:0] wide;

   always_comb begin
      prod = mag * mag;
      wide = (admm_st_pkg::WIDE_W'(prod) >> admm_st_pkg::SQ_RSH) << admm_st_pkg::SQ_LSH;
      if (|wide[admm_st_pkg::WIDE_W-1:admm_st_pkg::SUM_W]) begin
         square = '1;
      end else begin
         square = wide[admm_st_pkg::SUM_W-1:0];
      end
   end

endmodule

[hw/rtl/admm_st_accum.sv]
// Running sums of squares with first-element clear and saturating add.
`timescale 1ns / 1ps

module admm_st_accum (
   input  logic                   clock,
   input  logic                   reset,
   input  admm_st_pkg::acc_ctl_type ctl,
   input  admm_st_pkg::sums_type  squares,
   output admm_st_pkg::sums_type  sums
);

   admm_st_pkg::sums_type acc_ff;
   admm_st_pkg::sums_type acc_in;

   always_comb begin
      acc_in = acc_ff;
      for (int i = 0; i < admm_st_pkg::NUM_SUMS; i++) begin
         logic [admm_st_pkg::SUM_W:0] total;
         admm_st_pkg::sum_type        base;
         base  = ctl.first ? '0 : acc_ff[i];
         total = {1'b0, base} + {1'b0, squares[i]};
         if (ctl.load) begin
            if (ctl.enable) begin
               acc_in[i] = total[admm_st_pkg::SUM_W] ? '1 : total[admm_st_pkg::SUM_W-1:0];
            end else begin
               acc_in[i] = base;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assign sums = acc_ff;

endmodule

[sim/tb_admm_soft_threshold_step.sv]
// Self-checking stream testbench for admm_soft_threshold_step with a predicting scoreboard.
`timescale 1ns / 1ps

module tb_admm_soft_threshold_step;

   localparam int CLK_HALF     = 6;
   localparam int FRAC         = 16;
   localparam int VAL_W        = 32;
   localparam int SQ_SHIFT     = 2 * FRAC - 32;   // square fraction bits minus Q32.32
   localparam int DRAIN_CYCLES = 8;               // four pipeline stages, with margin
   localparam int QUIET_LIMIT  = 1000;            // cycles without any transaction
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 100;

   localparam longint VAL_HI = (longint'(1) << (VAL_W - 1)) - 1;
   localparam longint VAL_LO = -VAL_HI - 1;

   localparam logic [31:0] V_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] V_MIN = 32'h8000_0000;

   // indexes outside the register map; writes to them must change nothing
   localparam logic [admm_st_pkg::CSR_IDX_W-1:0] CSR_SPARE_LOW = admm_st_pkg::CSR_IDX_W'(2);
   localparam logic [admm_st_pkg::CSR_IDX_W-1:0] CSR_SPARE_TOP = '1;

   typedef enum int {PRIMAL_SUM, CHANGE_SUM, COEF_SUM, SPLIT_SUM, DUAL_SUM, NUM_SUMS} sum_slot_type;

   typedef struct packed {
      logic [31:0]                split;
      logic [31:0]                dual;
      logic [NUM_SUMS-1:0][63:0]  sums;
   } update_type;

   // Predicts each element update and checks result transactions in order.
   class soft_threshold_checker;
      logic [30:0] threshold;
      bit          residuals_on;
      logic [63:0] sums [NUM_SUMS];
      update_type  expected_updates[$];
      int          errors;
      string       sum_names [NUM_SUMS] = '{"primal_sq_sum", "change_sq_sum",
                                             "coef_sq_sum", "split_sq_sum", "dual_sq_sum"};

      function new();
         threshold    = '0;
         residuals_on = 1'b1;
         foreach (sums[k]) sums[k] = '0;
         errors = 0;
      endfunction

      function longint clamp_value(longint v);
         return (v > VAL_HI) ? VAL_HI : ((v < VAL_LO) ? VAL_LO : v);
      endfunction

      // |v|^2 realigned to 32 fraction bits, saturated to 64 bits
      function logic [63:0] square_q32(longint v);
         logic [63:0]  mag;
         logic [127:0] prod;
         mag  = (v < 0) ? 64'(-v) : 64'(v);
         prod = 128'(mag) * 128'(mag);
         if (SQ_SHIFT >= 0) prod = prod >> SQ_SHIFT;
         else               prod = prod << (-SQ_SHIFT);
         return (prod[127:64] != '0) ? '1 : prod[63:0];
      endfunction

      function logic [63:0] add_saturated(logic [63:0] acc, logic [63:0] x);
         logic [64:0] s;
         s = {1'b0, acc} + {1'b0, x};
         return s[64] ? '1 : s[63:0];
      endfunction

      function void write_register(logic [admm_st_pkg::CSR_IDX_W-1:0] addr, logic [31:0] data);
         if (addr == admm_st_pkg::CSR_THRESHOLD) threshold = data[30:0];
         else if (addr == admm_st_pkg::CSR_RESIDUAL_EN) residuals_on = data[0];
      endfunction

      function void note_element(logic [95:0] data, logic first);
         longint     coef, old_split, old_dual, thr, w, z, h;
         update_type upd;
         coef      = clamp_value($signed(data[31:0]));
         old_split = clamp_value($signed(data[63:32]));
         old_dual  = clamp_value($signed(data[95:64]));
         thr       = longint'(threshold);
         w = clamp_value(coef + old_dual);
         if (w > thr)       z = w - thr;
         else if (w < -thr) z = w + thr;
         else               z = 0;
         h = clamp_value(w - z);
         if (first) foreach (sums[k]) sums[k] = '0;
         if (residuals_on) begin
            sums[PRIMAL_SUM] = add_saturated(sums[PRIMAL_SUM], square_q32(clamp_value(coef - z)));
            sums[CHANGE_SUM] = add_saturated(sums[CHANGE_SUM],
                                             square_q32(clamp_value(z - old_split)));
            sums[COEF_SUM]   = add_saturated(sums[COEF_SUM], square_q32(coef));
            sums[SPLIT_SUM]  = add_saturated(sums[SPLIT_SUM], square_q32(z));
            sums[DUAL_SUM]   = add_saturated(sums[DUAL_SUM], square_q32(h));
         end
         upd.split = 32'(z);
         upd.dual  = 32'(h);
         foreach (sums[k]) upd.sums[k] = sums[k];
         expected_updates = {expected_updates, upd};
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0h, actual %0h", name, want, got);
         end
      endfunction

      function void check_update(logic [383:0] data);
         update_type want;
         if (expected_updates.size() == 0) begin
            errors++;
            $error("result transaction with no element pending");
            return;
         end
         want = expected_updates.pop_front();
         compare_field("split_value", 64'(want.split), 64'(data[31:0]));
         compare_field("dual_value", 64'(want.dual), 64'(data[63:32]));
         foreach (sum_names[k]) compare_field(sum_names[k], want.sums[k], data[64 + 64*k +: 64]);
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  req_tdata = '0;        // coef_value, prev_split, prev_dual
   logic         req_tuser = 1'b0;      // first_element
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [383:0] rsp_tdata;             // split_value, dual_value, primal_sq_sum,
                                        // change_sq_sum, coef_sq_sum, split_sq_sum,
                                        // dual_sq_sum
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [admm_st_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]  csr_data = '0;

   soft_threshold_checker tracker = new();

   int idle_pct   = 0;   // chance of an idle burst, both sides; zero in the closing phase
   int stall_left = 0;
   int quiet_cycles = 0;

   admm_soft_threshold_step uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #CLK_HALF clock = ~clock;

   // All three channels are observed at the same edge, before any NBA lands, so
   // register writes, accepted elements and results reach the scoreboard in order.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_data);
         if (req_tvalid && req_tready) tracker.note_element(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) tracker.check_update(rsp_tdata);
      end
   end

   // Result-side back-pressure: ready drops for bursts of random length.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 399) < idle_pct) begin
         stall_left <= $urandom_range(1, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: a long stretch with no transaction on any channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("** admm_soft_threshold_step: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one element after an optional idle burst and holds it until taken.
   // Valid stays high on return so back-to-back elements need no extra NBA.
   task automatic send_element(input logic [31:0] coef, input logic [31:0] split,
                               input logic [31:0] dual, input logic first);
      int gap;
      gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 11) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dual, split, coef};
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drops valid, waits for every pending result, then lets the pipe go quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_updates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register transaction; the trailing idle cycle keeps csr_valid to one
   // NBA per time step when writes follow each other.
   task automatic write_csr(input logic [admm_st_pkg::CSR_IDX_W-1:0] addr,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= addr;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Element values: mostly near zero for narrow runs so the sums stay
   // meaningful, with full-range and edge values mixed in.
   function automatic logic [31:0] pick_value(bit narrow);
      int roll;
      int near;
      roll = $urandom_range(0, 99);
      near = int'($urandom_range(0, 2097152)) - 1048576;
      if (narrow && roll < 85) return 32'(near);
      if (roll < 93) begin
         case ($urandom_range(0, 4))
            0:       return V_MAX;
            1:       return V_MIN;
            2:       return 32'h0000_0001;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // Threshold data, bit 31 random since the register keeps only 31 bits.
   function automatic logic [31:0] pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         5:       return $urandom;
         default: return {1'($urandom_range(0, 1)), 31'($urandom_range(0, 1048576))};
      endcase
   endfunction

   initial begin
      int  run_left;
      bit  narrow;
      bit  head;
      bit  first;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset settings, threshold zero, residuals on ---
      send_element(32'h0, 32'h0, 32'h0, 1'b1);
      send_element(V_MAX, V_MIN, V_MAX, 1'b0);       // w saturates high, split change too
      send_element(V_MIN, V_MAX, V_MIN, 1'b0);       // w saturates low
      send_element(32'h0, 32'h0, V_MIN, 1'b0);       // coef minus split saturates
      send_element(V_MAX, V_MAX, V_MAX, 1'b0);
      send_element(V_MIN, V_MIN, 32'h0, 1'b0);       // running sums hit their ceiling

      // --- directed: threshold 1.5, each side of the dead zone and its edges ---
      settle();
      write_csr(admm_st_pkg::CSR_THRESHOLD, 32'h0001_8000);
      send_element(32'h0003_0000, 32'h0, 32'h0, 1'b1);          // above threshold
      send_element(32'hFFFD_0000, 32'h0, 32'h0, 1'b0);          // below minus threshold
      send_element(32'h0000_8000, 32'h0, 32'h0, 1'b0);          // inside the dead zone
      send_element(32'h0001_0000, 32'h0, 32'h0000_8000, 1'b0);  // exactly on threshold
      send_element(32'hFFFE_8000, 32'h0, 32'h0, 1'b0);          // exactly on minus threshold

      // --- directed: widest threshold, residuals off, unmapped indexes ---
      settle();
      write_csr(admm_st_pkg::CSR_THRESHOLD, 32'hFFFF_FFFF);
      write_csr(admm_st_pkg::CSR_RESIDUAL_EN, 32'h0000_0000);
      write_csr(CSR_SPARE_LOW, 32'hFFFF_FFFF);
      write_csr(CSR_SPARE_TOP, 32'hA5A5_5A5B);
      send_element(V_MAX, 32'h0, 32'h0, 1'b1);       // clear while disabled, then hold
      send_element(V_MIN, 32'h0, 32'h0, 1'b0);
      send_element(32'h0, V_MAX, V_MIN, 1'b0);

      // enable bit only: upper data bits must not turn accumulation on
      settle();
      write_csr(admm_st_pkg::CSR_RESIDUAL_EN, 32'hFFFF_FFFE);
      send_element(32'h1234_5678, 32'hFFFF_FFFB, 32'h0000_0007, 1'b0);
      settle();
      write_csr(admm_st_pkg::CSR_RESIDUAL_EN, 32'h0000_0001);
      write_csr(admm_st_pkg::CSR_THRESHOLD, 32'h0000_0000);
      send_element(32'h1234_5678, 32'hFFFF_FFFB, 32'h0000_0007, 1'b0);
      send_element(32'hFFFF_0000, 32'h0002_0000, 32'h0000_4000, 1'b0);

      // --- random: vectors of random length, each opened by a first element ---
      run_left = 0;
      narrow   = 1'b1;
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         write_csr(admm_st_pkg::CSR_THRESHOLD, pick_threshold());
         write_csr(admm_st_pkg::CSR_RESIDUAL_EN,
                   ($urandom & 32'hFFFF_FFFE) | 32'($urandom_range(0, 3) != 0));
         case ($urandom_range(0, 3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
         endcase
         if (phase == PHASES - 1) idle_pct = 0;   // closing phase runs flat out
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            head = 1'b0;
            if (run_left == 0) begin
               run_left = $urandom_range(1, 40);
               narrow   = ($urandom_range(0, 3) != 0);
               head     = 1'b1;
            end
            run_left--;
            // stray first flags mid-vector act as noise
            first = head || ($urandom_range(0, 49) == 0);
            send_element(pick_value(narrow), pick_value(narrow), pick_value(narrow), first);
         end
      end

      settle();
      if (tracker.errors == 0) begin
         $display("** admm_soft_threshold_step: PASSED **");
      end else begin
         $display("** admm_soft_threshold_step: FAILED **");
      end
      $finish;
   end

endmodule
